### rtl/core/sat_pkg.sv
// Shared types and constants for the shift array table.
// Used by sat_cell, shift_array_table and tb_top; depends on nothing else.
package sat_pkg;

    // Table geometry.
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Operation codes carried in the input transaction.
    typedef enum logic [2:0] {
        OP_INSERT_AT    = 3'd0,
        OP_INSERT_FIRST = 3'd1,
        OP_INSERT_LAST  = 3'd2,
        OP_DELETE       = 3'd3,
        OP_SEARCH       = 3'd4,
        OP_REVERSE      = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_BADPOS   = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    // What every cell does in the current cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    // Command broadcast along the row of cells.
    typedef struct packed {
        cell_op_t                  kind;
        logic [CNT_W-1:0]          pos;
        logic [CNT_W-1:0]          lim;
        logic signed [DATA_W-1:0]  data;
    } cell_cmd_t;

    // Controller state.
    typedef enum logic {
        ST_IDLE    = 1'b0,
        ST_REVERSE = 1'b1
    } state_t;

endpackage

### rtl/core/shift_array_table.sv
// Top level of the shift array table: controller, result register and the
// row of sat_cell instances. Depends on sat_pkg and sat_cell.
//
//   Channel | Direction | Payload (low bits first)
//   s_      | in        | operation[2:0], position[7:3], value[39:8]
//   m_      | out       | status[2:0], found_index[6:3], entry_count[11:7]
//
// Insert, delete, search and unused codes complete on acceptance; every cell acts in parallel.
// A reverse of n >= 2 entries runs as prefix rotations of the cell row, of lengths n down
// to 2, one rotation per cycle; a reverse of zero or one entry needs none. The last rotation
// waits for the output register to be free.
// Reset clears the entry count and control; entries are not cleared.
// A result waits in the output register; a new transaction is taken only with no reverse
// in progress and that register free or being drained in the same cycle.
module shift_array_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], position[7:3], value[39:8]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], found_index[6:3], entry_count[11:7], zero[15:12]
    output logic [15:0] m_tdata
);

    localparam int DEPTH  = sat_pkg::DEPTH;
    localparam int DATA_W = sat_pkg::DATA_W;
    localparam int IDX_W  = sat_pkg::IDX_W;
    localparam int CNT_W  = sat_pkg::CNT_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // Input fields.
    sat_pkg::op_t              in_op;
    logic [CNT_W-1:0]          in_pos;
    logic signed [DATA_W-1:0]  in_value;

    assign in_op    = sat_pkg::op_t'(s_tdata[2:0]);
    assign in_pos   = s_tdata[7:3];
    assign in_value = s_tdata[39:8];

    // Control state.
    sat_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rot_len_reg, rot_len_next;
    logic              m_tvalid_reg, m_tvalid_next;
    sat_pkg::status_t  status_reg, status_next;
    logic [IDX_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    // Row of cells.
    sat_pkg::cell_cmd_t        cmd;
    logic signed [DATA_W-1:0]  cell_entry [DEPTH];
    logic [DEPTH-1:0]          cell_match;

    logic              in_fire;
    logic              out_free;
    logic              res_valid;
    sat_pkg::status_t  res_status;
    logic [IDX_W-1:0]  res_found;
    logic [CNT_W-1:0]  ins_pos;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == sat_pkg::ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    // Cell chain: each cell sees its neighbors and the head entry.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_entry[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_entry[i+1];
        end

        sat_cell u_cell (
            .aclk       (aclk),
            .idx        (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_entry[0]),
            .entry      (cell_entry[i]),
            .match      (cell_match[i])
        );
    end

    // First matching cell wins.
    always_comb begin
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end
    assign hit = |cell_match;

    // Next-state, cell command and result logic.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rot_len_next = rot_len_reg;
        res_valid    = 1'b0;
        res_status   = sat_pkg::STAT_OK;
        res_found    = '0;
        ins_pos      = in_pos;
        cmd.kind     = sat_pkg::CELL_HOLD;
        cmd.pos      = in_pos;
        cmd.lim      = count_reg;
        cmd.data     = in_value;

        case (state_reg)
            sat_pkg::ST_IDLE: begin
                if (in_fire) begin
                    res_valid = 1'b1;
                    case (in_op)
                        sat_pkg::OP_INSERT_AT,
                        sat_pkg::OP_INSERT_FIRST,
                        sat_pkg::OP_INSERT_LAST: begin
                            if (in_op == sat_pkg::OP_INSERT_FIRST) begin
                                ins_pos = '0;
                            end else if (in_op == sat_pkg::OP_INSERT_LAST) begin
                                ins_pos = count_reg;
                            end
                            if (ins_pos > count_reg) begin
                                res_status = sat_pkg::STAT_BADPOS;
                            end else if (count_reg == FULL_CNT) begin
                                res_status = sat_pkg::STAT_FULL;
                            end else begin
                                cmd.kind   = sat_pkg::CELL_INSERT;
                                cmd.pos    = ins_pos;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        sat_pkg::OP_DELETE: begin
                            if (count_reg == '0) begin
                                res_status = sat_pkg::STAT_EMPTY;
                            end else if (in_pos >= count_reg) begin
                                res_status = sat_pkg::STAT_BADPOS;
                            end else begin
                                cmd.kind   = sat_pkg::CELL_DELETE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        sat_pkg::OP_SEARCH: begin
                            if (count_reg == '0) begin
                                res_status = sat_pkg::STAT_EMPTY;
                            end else if (hit) begin
                                res_found = hit_idx;
                            end else begin
                                res_status = sat_pkg::STAT_NOTFOUND;
                            end
                        end
                        sat_pkg::OP_REVERSE: begin
                            if (count_reg == '0) begin
                                res_status = sat_pkg::STAT_EMPTY;
                            end else if (count_reg != CNT_W'(1)) begin
                                // First rotation now; more follow if needed.
                                cmd.kind = sat_pkg::CELL_ROTATE;
                                if (count_reg != CNT_W'(2)) begin
                                    res_valid    = 1'b0;
                                    rot_len_next = count_reg - 1'b1;
                                    state_next   = sat_pkg::ST_REVERSE;
                                end
                            end
                        end
                        default: begin
                            res_status = sat_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            sat_pkg::ST_REVERSE: begin
                // The final rotation waits until the result register is free.
                if (rot_len_reg != CNT_W'(2) || out_free) begin
                    cmd.kind = sat_pkg::CELL_ROTATE;
                    cmd.lim  = rot_len_reg;
                    if (rot_len_reg == CNT_W'(2)) begin
                        res_valid  = 1'b1;
                        state_next = sat_pkg::ST_IDLE;
                    end else begin
                        rot_len_next = rot_len_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = sat_pkg::ST_IDLE;
            end
        endcase

        // Output register handshake.
        if (res_valid) begin
            m_tvalid_next  = 1'b1;
            status_next    = res_status;
            found_next     = res_found;
            out_count_next = count_next;
        end else begin
            m_tvalid_next  = m_tvalid_reg && !m_tready;
            status_next    = status_reg;
            found_next     = found_reg;
            out_count_next = out_count_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sat_pkg::ST_IDLE;
            count_reg    <= '0;
            rot_len_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rot_len_reg  <= rot_len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        found_reg     <= found_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_count_reg, found_reg, status_reg};

`ifndef SYNTHESIS
    // The entry count never exceeds the table depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count beyond table depth");

    // A reverse in progress always has a prefix of two or more within the count.
    a_rot_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sat_pkg::ST_REVERSE |-> (rot_len_reg >= CNT_W'(2) &&
                                              rot_len_reg <= count_reg))
        else $error("reverse prefix length out of range");

    // A reverse never changes the count.
    a_rev_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sat_pkg::ST_REVERSE |=> count_reg == $past(count_reg))
        else $error("count changed during reverse");

    // A nonzero found index comes only with an ok status.
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && found_reg != '0) |-> status_reg == sat_pkg::STAT_OK)
        else $error("found index without ok status");

    // No new transaction is taken during a reverse.
    a_busy_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sat_pkg::ST_REVERSE |-> !s_tready)
        else $error("input taken while reversing");
`endif

endmodule

### rtl/core/sat_cell.sv
// One storage cell of the shift array table: holds one entry and trades it
// with its neighbors under the broadcast command. Depends on sat_pkg.
module sat_cell (
    input  logic                                aclk,
    input  logic [sat_pkg::IDX_W-1:0]           idx,
    input  sat_pkg::cell_cmd_t                  cmd,
    input  logic signed [sat_pkg::DATA_W-1:0]   left_data,
    input  logic signed [sat_pkg::DATA_W-1:0]   right_data,
    input  logic signed [sat_pkg::DATA_W-1:0]   head_data,
    output logic signed [sat_pkg::DATA_W-1:0]   entry,
    output logic                                match
);

    logic signed [sat_pkg::DATA_W-1:0] entry_reg;
    logic signed [sat_pkg::DATA_W-1:0] entry_next;
    logic [sat_pkg::CNT_W-1:0]         my_idx;

    assign my_idx = sat_pkg::CNT_W'(idx);

    // Pick the new entry value from this cell or a neighbor.
    always_comb begin
        entry_next = entry_reg;
        case (cmd.kind)
            sat_pkg::CELL_INSERT: begin
                if (my_idx == cmd.pos) begin
                    entry_next = cmd.data;
                end else if (my_idx > cmd.pos && my_idx <= cmd.lim) begin
                    entry_next = left_data;
                end
            end
            sat_pkg::CELL_DELETE: begin
                if (my_idx >= cmd.pos && (my_idx + 1'b1) < cmd.lim) begin
                    entry_next = right_data;
                end
            end
            sat_pkg::CELL_ROTATE: begin
                // Rotate the prefix of length lim left by one place.
                if ((my_idx + 1'b1) < cmd.lim) begin
                    entry_next = right_data;
                end else if ((my_idx + 1'b1) == cmd.lim) begin
                    entry_next = head_data;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    // Compare against the search key; only stored entries count.
    assign match = (my_idx < cmd.lim) && (entry_reg == cmd.data);
    assign entry = entry_reg;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for shift_array_table: drives table operations over the
// stream input, predicts every result in a scoreboard and compares it field by field.
// Depends on sat_pkg and the shift_array_table RTL.
module tb_top;

    localparam int DEPTH  = sat_pkg::DEPTH;
    localparam int DATA_W = sat_pkg::DATA_W;
    localparam int IDX_W  = sat_pkg::IDX_W;
    localparam int CNT_W  = sat_pkg::CNT_W;

    // Operation codes the block does not define; it must pass them through unchanged.
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    // One expected result transaction.
    typedef struct {
        sat_pkg::status_t status;
        logic [IDX_W-1:0] found_index;
        logic [CNT_W-1:0] entry_count;
    } table_result_t;

    // Scoreboard: its own copy of the table, plus the queue of outstanding results.
    class table_scoreboard;
        logic [DATA_W-1:0] slots [DEPTH];
        int unsigned       cnt;
        table_result_t     awaited [$];
        int                errors;

        function new();
            cnt    = 0;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return awaited.size();
        endfunction

        // Shared by the three insert operations.
        function sat_pkg::status_t insert_entry(input int unsigned pos,
                                                input logic [DATA_W-1:0] val);
            if (pos > cnt) return sat_pkg::STAT_BADPOS;
            if (cnt >= DEPTH) return sat_pkg::STAT_FULL;
            for (int k = cnt; k > pos; k--) slots[k] = slots[k-1];
            slots[pos] = val;
            cnt++;
            return sat_pkg::STAT_OK;
        endfunction

        // Apply one accepted input transaction to the table and queue its result.
        function void note_input(input logic [2:0] op, input logic [4:0] pos,
                                 input logic [DATA_W-1:0] val);
            table_result_t res;
            logic [DATA_W-1:0] tmp;
            res.status      = sat_pkg::STAT_OK;
            res.found_index = '0;
            case (op)
                sat_pkg::OP_INSERT_AT:    res.status = insert_entry(pos, val);
                sat_pkg::OP_INSERT_FIRST: res.status = insert_entry(0, val);
                sat_pkg::OP_INSERT_LAST:  res.status = insert_entry(cnt, val);
                sat_pkg::OP_DELETE: begin
                    if (cnt == 0) begin
                        res.status = sat_pkg::STAT_EMPTY;
                    end else if (pos >= cnt) begin
                        res.status = sat_pkg::STAT_BADPOS;
                    end else begin
                        for (int k = pos + 1; k < cnt; k++) slots[k-1] = slots[k];
                        cnt--;
                    end
                end
                sat_pkg::OP_SEARCH: begin
                    if (cnt == 0) begin
                        res.status = sat_pkg::STAT_EMPTY;
                    end else begin
                        res.status = sat_pkg::STAT_NOTFOUND;
                        for (int k = 0; k < cnt; k++) begin
                            if (slots[k] == val) begin
                                res.status      = sat_pkg::STAT_OK;
                                res.found_index = k[IDX_W-1:0];
                                break;
                            end
                        end
                    end
                end
                sat_pkg::OP_REVERSE: begin
                    if (cnt == 0) begin
                        res.status = sat_pkg::STAT_EMPTY;
                    end else begin
                        for (int k = 0; k < cnt / 2; k++) begin
                            tmp              = slots[cnt-1-k];
                            slots[cnt-1-k]   = slots[k];
                            slots[k]         = tmp;
                        end
                    end
                end
                default: ;
            endcase
            res.entry_count = cnt[CNT_W-1:0];
            awaited.push_back(res);
        endfunction

        // Compare one accepted result transaction with the oldest expectation.
        task check_result(input logic [15:0] data);
            table_result_t want;
            if (awaited.size() == 0) begin
                report($sformatf("result 0x%04h arrived with nothing outstanding", data));
                return;
            end
            want = awaited.pop_front();
            if (data[2:0] !== want.status)
                report($sformatf("status got %0d, expected %0d", data[2:0], want.status));
            if (data[6:3] !== want.found_index)
                report($sformatf("found_index got %0d, expected %0d",
                                 data[6:3], want.found_index));
            if (data[11:7] !== want.entry_count)
                report($sformatf("entry_count got %0d, expected %0d",
                                 data[11:7], want.entry_count));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int send_idle_pct = 20;
    int recv_idle_pct = 46;

    table_scoreboard sb = new();

    shift_array_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: check each accepted transaction, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("[shift_array_table] ERROR");
        $finish;
    end

    // Present one input transaction, with random idle cycles ahead of it.
    task automatic send_item(input logic [2:0] op, input logic [4:0] pos,
                             input logic [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, pos, val);
    endtask

    // Mix of stored entries, a small pool that yields duplicates, extremes and noise.
    function automatic logic [DATA_W-1:0] pick_value(input bit as_key);
        int r;
        r = $urandom_range(9);
        if (as_key && sb.cnt > 0 && r < 6) return sb.slots[$urandom_range(sb.cnt - 1)];
        case (r % 5)
            0, 1: return DATA_W'($urandom_range(7)) - 32'd4;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Random traffic that swings the table between empty and full.
    task automatic run_random(input int n_items);
        int          done;
        int          r;
        int          ins_pct;
        int          del_pct;
        bit          filling;
        logic [2:0]  op;
        logic [4:0]  pos;
        done    = 0;
        filling = 1'b1;
        while (done < n_items) begin
            if (sb.cnt == DEPTH && $urandom_range(1) == 0) filling = 1'b0;
            else if (sb.cnt == 0) filling = 1'b1;
            else if ($urandom_range(59) == 0) filling = !filling;
            ins_pct = filling ? 50 : 20;
            del_pct = filling ? 15 : 45;
            r = $urandom_range(99);
            if (r < ins_pct) begin
                case ($urandom_range(2))
                    0: op = sat_pkg::OP_INSERT_AT;
                    1: op = sat_pkg::OP_INSERT_FIRST;
                    default: op = sat_pkg::OP_INSERT_LAST;
                endcase
                pos = ($urandom_range(4) == 0) ? 5'($urandom_range(16))
                                               : 5'($urandom_range(sb.cnt));
                send_item(op, pos, pick_value(1'b0));
                done++;
            end else if (r < ins_pct + del_pct) begin
                pos = ($urandom_range(4) == 0 || sb.cnt == 0) ? 5'($urandom_range(16))
                                                               : 5'($urandom_range(sb.cnt - 1));
                send_item(sat_pkg::OP_DELETE, pos, pick_value(1'b0));
                done++;
            end else if (r < ins_pct + del_pct + 20) begin
                send_item(sat_pkg::OP_SEARCH, 5'($urandom_range(16)), pick_value(1'b1));
                done++;
            end else if (r < ins_pct + del_pct + 30) begin
                send_item(sat_pkg::OP_REVERSE, 5'($urandom_range(16)), $urandom);
                done++;
            end else begin
                // Undefined codes count toward the item total like any other.
                send_item($urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7,
                          5'($urandom_range(16)), $urandom);
                done++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table cases and an insert past the end.
        send_item(sat_pkg::OP_DELETE,    5'd0, 32'd0);
        send_item(sat_pkg::OP_SEARCH,    5'd0, 32'd0);
        send_item(sat_pkg::OP_REVERSE,   5'd0, 32'd0);
        send_item(sat_pkg::OP_INSERT_AT, 5'd1, 32'd9);

        // Value extremes through each insert flavor, then one in the middle.
        send_item(sat_pkg::OP_INSERT_AT,    5'd0, 32'h8000_0000);
        send_item(sat_pkg::OP_INSERT_LAST,  5'd0, 32'h7FFF_FFFF);
        send_item(sat_pkg::OP_INSERT_FIRST, 5'd0, 32'h0000_0000);
        send_item(sat_pkg::OP_INSERT_FIRST, 5'd0, 32'hFFFF_FFFF);
        send_item(sat_pkg::OP_INSERT_AT,    5'd2, 32'd5);

        // Search hit and miss, reverse, delete at the last slot, just past it and far beyond.
        send_item(sat_pkg::OP_SEARCH,  5'd0, 32'h7FFF_FFFF);
        send_item(sat_pkg::OP_SEARCH,  5'd0, 32'd12345);
        send_item(sat_pkg::OP_REVERSE, 5'd0, 32'd0);
        send_item(sat_pkg::OP_DELETE,  5'd4, 32'd0);
        send_item(sat_pkg::OP_DELETE,  5'd4, 32'd0);
        send_item(sat_pkg::OP_DELETE,  5'd16, 32'd0);

        // Undefined operation codes.
        send_item(OP_UNUSED_6, 5'd31, 32'hFFFF_FFFF);
        send_item(OP_UNUSED_7, 5'd0, 32'h0);

        // Fill up, then every insert flavor against a full table, a full reverse, a search and a delete.
        while (sb.cnt < DEPTH) send_item(sat_pkg::OP_INSERT_LAST, 5'd0, $urandom);
        send_item(sat_pkg::OP_INSERT_FIRST, 5'd0, 32'd1);
        send_item(sat_pkg::OP_INSERT_AT,    5'd16, 32'd1);
        send_item(sat_pkg::OP_INSERT_LAST,  5'd0, 32'd1);
        send_item(sat_pkg::OP_REVERSE,      5'd0, 32'd0);
        send_item(sat_pkg::OP_SEARCH,       5'd0, sb.slots[DEPTH-1]);
        send_item(sat_pkg::OP_DELETE,       5'd15, 32'd0);

        run_random(280);
        send_idle_pct = 46;
        recv_idle_pct = 20;
        run_random(280);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(280);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (2 * DEPTH) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[shift_array_table] OK");
        end else begin
            $display("[shift_array_table] ERROR");
        end
        $finish;
    end
endmodule
